>>> design/sdm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdm_pkg: shared types and constants for the stereo downmixer
// Sample and accumulator types, Q1.15 mix weights, 1/sqrt(n) gain table,
// channel count clamp and mix mode decode.
// ----------------------------------------------------------------------------
package sdm_pkg;

  localparam int CHANNELS = 8;
  localparam int SAMPLE_W = 24;   // Q1.23 input samples
  localparam int OUT_W    = 26;   // Q3.23 output samples
  localparam int COUNT_W  = 4;
  localparam int SUM_W    = 27;   // sum of eight samples
  localparam int ACC_W    = 42;   // Q.38 accumulator with headroom
  localparam int COEF_W   = 16;   // unsigned Q1.15 weights
  localparam int FRAC_SH  = 15;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [OUT_W-1:0]    out_t;
  typedef logic [COUNT_W-1:0]         count_t;
  typedef logic [COEF_W-1:0]          coef_t;

  // Q1.15 mix weights
  localparam coef_t COEF_ONE  = 16'd32768;
  localparam coef_t COEF_0707 = 16'd23167;
  localparam coef_t COEF_05   = 16'd16384;
  localparam coef_t COEF_03   = 16'd9830;

  // Rounding constant for the Q.38 accumulator, saturation bounds on the rounded Q.23 value
  localparam acc_t ROUND_HALF = acc_t'(16384);
  localparam acc_t OUT_MAX    = acc_t'(33554431);
  localparam acc_t OUT_MIN    = -acc_t'(33554432);

  typedef enum logic [3:0] {
    MODE_PASS,    // equal counts
    MODE_UP,      // mono to stereo
    MODE_DOWN,    // stereo to mono
    MODE_3_0,
    MODE_QUAD,
    MODE_5_0,
    MODE_5_1,
    MODE_7_1,
    MODE_SPREAD   // any other pair: gained sum into every output
  } mode_e;

  typedef struct packed {
    logic   valid;
    count_t count;   // clamped target count
    mode_e  mode;
  } ctrl_t;

  // Zero acts as one, anything above CHANNELS acts as CHANNELS
  function automatic count_t clamp_count(count_t v);
    count_t r;
    if (v == '0) begin
      r = count_t'(1);
    end else if (v > count_t'(CHANNELS)) begin
      r = count_t'(CHANNELS);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // 1/sqrt(n) in Q1.15
  function automatic coef_t inv_sqrt(count_t n);
    coef_t g;
    case (n)
      4'd1:    g = 16'd32768;
      4'd2:    g = 16'd23170;
      4'd3:    g = 16'd18919;
      4'd4:    g = 16'd16384;
      4'd5:    g = 16'd14654;
      4'd6:    g = 16'd13378;
      4'd7:    g = 16'd12385;
      default: g = 16'd11585;
    endcase
    return g;
  endfunction

  // Signed value times unsigned Q1.15 weight, result in accumulator width
  function automatic acc_t mul_coef(sum_t x, coef_t c);
    acc_t xe;
    acc_t ce;
    xe = acc_t'(x);
    ce = $signed(ACC_W'(c));
    return xe * ce;
  endfunction

  // Mix mode from clamped input and target counts
  function automatic mode_e decode_mode(count_t n, count_t t);
    mode_e m;
    if (n == t) begin
      m = MODE_PASS;
    end else if (n == 4'd1 && t == 4'd2) begin
      m = MODE_UP;
    end else if (n == 4'd2 && t == 4'd1) begin
      m = MODE_DOWN;
    end else if (t == 4'd2 && n == 4'd3) begin
      m = MODE_3_0;
    end else if (t == 4'd2 && n == 4'd4) begin
      m = MODE_QUAD;
    end else if (t == 4'd2 && n == 4'd5) begin
      m = MODE_5_0;
    end else if (t == 4'd2 && n == 4'd6) begin
      m = MODE_5_1;
    end else if (t == 4'd2 && n == 4'd8) begin
      m = MODE_7_1;
    end else begin
      m = MODE_SPREAD;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

>>> design/sdm_input.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdm_input: input register stage
// Clamps counts, picks the mix mode, masks unused samples and registers the
// frame together with the plain sample sum and its 1/sqrt(n) gain.
// ----------------------------------------------------------------------------
module sdm_input (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire sdm_pkg::count_t   num_in_i,
  input  wire sdm_pkg::count_t   target_i,
  input  wire sdm_pkg::sample_t  smp_i [sdm_pkg::CHANNELS],
  output sdm_pkg::ctrl_t         ctrl_o,
  output sdm_pkg::sample_t       smp_o [sdm_pkg::CHANNELS],
  output sdm_pkg::sum_t          sum_o,
  output sdm_pkg::coef_t         gain_o
);

  sdm_pkg::count_t  n_cnt;
  sdm_pkg::count_t  t_cnt;
  sdm_pkg::sample_t smp_d [sdm_pkg::CHANNELS];
  sdm_pkg::sum_t    sum_d;
  sdm_pkg::ctrl_t   ctrl_d;
  logic             valid_q;
  sdm_pkg::count_t  count_q;
  sdm_pkg::mode_e   mode_q;
  sdm_pkg::sample_t smp_q [sdm_pkg::CHANNELS];
  sdm_pkg::sum_t    sum_q;
  sdm_pkg::coef_t   gain_q;

  // Count clamp, mode decode, sample mask and sum
  always_comb begin
    n_cnt = sdm_pkg::clamp_count(num_in_i);
    t_cnt = sdm_pkg::clamp_count(target_i);
    sum_d = '0;
    for (int k = 0; k < sdm_pkg::CHANNELS; k++) begin
      smp_d[k] = (sdm_pkg::count_t'(k) < n_cnt) ? smp_i[k] : '0;
      sum_d    = sum_d + sdm_pkg::SUM_W'(smp_d[k]);
    end
    ctrl_d.valid = accept_i;
    ctrl_d.count = t_cnt;
    ctrl_d.mode  = sdm_pkg::decode_mode(n_cnt, t_cnt);
  end

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_d.valid;
    end
  end

  // Payload, loaded on accept
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      count_q <= ctrl_d.count;
      mode_q  <= ctrl_d.mode;
      smp_q   <= smp_d;
      sum_q   <= sum_d;
      gain_q  <= sdm_pkg::inv_sqrt(n_cnt);
    end
  end

  assign ctrl_o = '{valid: valid_q, count: count_q, mode: mode_q};
  assign smp_o  = smp_q;
  assign sum_o  = sum_q;
  assign gain_o = gain_q;

endmodule
`default_nettype wire

>>> design/sdm_mix.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdm_mix: weighted sum stage
// Forms the Q.38 accumulator of every output channel for the mode in use and
// registers it.
// ----------------------------------------------------------------------------
module sdm_mix (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sdm_pkg::ctrl_t    ctrl_i,
  input  wire sdm_pkg::sample_t  smp_i [sdm_pkg::CHANNELS],
  input  wire sdm_pkg::sum_t     sum_i,
  input  wire sdm_pkg::coef_t    gain_i,
  output sdm_pkg::ctrl_t         ctrl_o,
  output sdm_pkg::acc_t          acc_o [sdm_pkg::CHANNELS]
);

  sdm_pkg::sum_t   s [sdm_pkg::CHANNELS];
  sdm_pkg::acc_t   one [sdm_pkg::CHANNELS];
  sdm_pkg::acc_t   w707 [sdm_pkg::CHANNELS];
  sdm_pkg::acc_t   w05 [sdm_pkg::CHANNELS];
  sdm_pkg::acc_t   w03;
  sdm_pkg::acc_t   spread;
  sdm_pkg::acc_t   acc_d [sdm_pkg::CHANNELS];
  logic            valid_q;
  sdm_pkg::count_t count_q;
  sdm_pkg::mode_e  mode_q;
  sdm_pkg::acc_t   acc_q [sdm_pkg::CHANNELS];

  // Weighted terms (constant weights, one gained sum)
  always_comb begin
    for (int k = 0; k < sdm_pkg::CHANNELS; k++) begin
      s[k]    = sdm_pkg::SUM_W'(smp_i[k]);
      one[k]  = sdm_pkg::mul_coef(s[k], sdm_pkg::COEF_ONE);
      w707[k] = sdm_pkg::mul_coef(s[k], sdm_pkg::COEF_0707);
      w05[k]  = sdm_pkg::mul_coef(s[k], sdm_pkg::COEF_05);
    end
    w03    = sdm_pkg::mul_coef(s[3], sdm_pkg::COEF_03);
    spread = sdm_pkg::mul_coef(sum_i, gain_i);
  end

  // Per-mode fold
  always_comb begin
    for (int k = 0; k < sdm_pkg::CHANNELS; k++) begin
      acc_d[k] = '0;
    end
    unique case (ctrl_i.mode)
      sdm_pkg::MODE_PASS: begin
        acc_d = one;
      end
      sdm_pkg::MODE_UP: begin
        acc_d[0] = one[0];
        acc_d[1] = one[0];
      end
      sdm_pkg::MODE_DOWN: begin
        acc_d[0] = w05[0] + w05[1];
      end
      sdm_pkg::MODE_3_0: begin
        acc_d[0] = one[0] + w707[2];
        acc_d[1] = one[1] + w707[2];
      end
      sdm_pkg::MODE_QUAD: begin
        acc_d[0] = one[0] + w707[2];
        acc_d[1] = one[1] + w707[3];
      end
      sdm_pkg::MODE_5_0: begin
        acc_d[0] = one[0] + w707[2] + w707[3];
        acc_d[1] = one[1] + w707[2] + w707[4];
      end
      sdm_pkg::MODE_5_1: begin
        acc_d[0] = one[0] + w707[2] + w707[4] + w03;
        acc_d[1] = one[1] + w707[2] + w707[5] + w03;
      end
      sdm_pkg::MODE_7_1: begin
        acc_d[0] = one[0] + w707[2] + w707[4] + w05[6] + w03;
        acc_d[1] = one[1] + w707[2] + w707[5] + w05[7] + w03;
      end
      default: begin
        for (int k = 0; k < sdm_pkg::CHANNELS; k++) begin
          acc_d[k] = spread;
        end
      end
    endcase
  end

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_i.valid;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      count_q <= ctrl_i.count;
      mode_q  <= ctrl_i.mode;
      acc_q   <= acc_d;
    end
  end

  assign ctrl_o = '{valid: valid_q, count: count_q, mode: mode_q};
  assign acc_o  = acc_q;

endmodule
`default_nettype wire

>>> design/sdm_finish.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdm_finish: result register stage
// Rounds each accumulator half up to Q3.23, saturates to 26 bits, zeroes
// channels beyond the target count and drives the result strobe.
// ----------------------------------------------------------------------------
module sdm_finish (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sdm_pkg::ctrl_t    ctrl_i,
  input  wire sdm_pkg::acc_t     acc_i [sdm_pkg::CHANNELS],
  output logic                   strobe_o,
  output sdm_pkg::count_t        count_o,
  output sdm_pkg::out_t          out_o [sdm_pkg::CHANNELS]
);

  sdm_pkg::acc_t   rnd [sdm_pkg::CHANNELS];
  sdm_pkg::acc_t   sat [sdm_pkg::CHANNELS];
  sdm_pkg::out_t   out_d [sdm_pkg::CHANNELS];
  logic            strobe_q;
  sdm_pkg::count_t count_q;
  sdm_pkg::out_t   out_q [sdm_pkg::CHANNELS];

  // Round half up (floor shift), saturate, mask unused channels
  always_comb begin
    for (int k = 0; k < sdm_pkg::CHANNELS; k++) begin
      rnd[k] = (acc_i[k] + sdm_pkg::ROUND_HALF) >>> sdm_pkg::FRAC_SH;
      if (rnd[k] > sdm_pkg::OUT_MAX) begin
        sat[k] = sdm_pkg::OUT_MAX;
      end else if (rnd[k] < sdm_pkg::OUT_MIN) begin
        sat[k] = sdm_pkg::OUT_MIN;
      end else begin
        sat[k] = rnd[k];
      end
      out_d[k] = (sdm_pkg::count_t'(k) < ctrl_i.count) ? sat[k][sdm_pkg::OUT_W-1:0] : '0;
    end
  end

  // Strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= ctrl_i.valid;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      count_q <= ctrl_i.count;
      out_q   <= out_d;
    end
  end

  assign strobe_o = strobe_q;
  assign count_o  = count_q;
  assign out_o    = out_q;

endmodule
`default_nettype wire

>>> design/multichannel_stereo_downmixer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_stereo_downmixer: eight-channel frame mixer to target count
// An accepted frame passes through the input, weighted sum and round/saturate registers to the result.
// Throughput: one item per cycle; busy is never raised, the three register
// stages (input, weighted sum, round/saturate) overlap items.
// Reset clears the stage valid flags and sets the target count to 2; no
// clearing pass. Results cannot be stalled; each strobe lasts one cycle.
// ----------------------------------------------------------------------------
module multichannel_stereo_downmixer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // item input
  input  wire logic              start,
  output logic                   busy,
  input  wire sdm_pkg::count_t   num_in_channels_i,
  input  wire sdm_pkg::sample_t  in_0_i,
  input  wire sdm_pkg::sample_t  in_1_i,
  input  wire sdm_pkg::sample_t  in_2_i,
  input  wire sdm_pkg::sample_t  in_3_i,
  input  wire sdm_pkg::sample_t  in_4_i,
  input  wire sdm_pkg::sample_t  in_5_i,
  input  wire sdm_pkg::sample_t  in_6_i,
  input  wire sdm_pkg::sample_t  in_7_i,
  // configuration write
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire sdm_pkg::count_t   cfg_data_i,
  // result
  output logic                   strobe_o,
  output sdm_pkg::count_t        out_count_o,
  output sdm_pkg::out_t          out_0_o,
  output sdm_pkg::out_t          out_1_o,
  output sdm_pkg::out_t          out_2_o,
  output sdm_pkg::out_t          out_3_o,
  output sdm_pkg::out_t          out_4_o,
  output sdm_pkg::out_t          out_5_o,
  output sdm_pkg::out_t          out_6_o,
  output sdm_pkg::out_t          out_7_o
);

  sdm_pkg::count_t  target_q;
  logic             accept;
  sdm_pkg::sample_t smp_in [sdm_pkg::CHANNELS];
  sdm_pkg::ctrl_t   in_ctrl;
  sdm_pkg::sample_t in_smp [sdm_pkg::CHANNELS];
  sdm_pkg::sum_t    in_sum;
  sdm_pkg::coef_t   in_gain;
  sdm_pkg::ctrl_t   mix_ctrl;
  sdm_pkg::acc_t    mix_acc [sdm_pkg::CHANNELS];
  sdm_pkg::out_t    res [sdm_pkg::CHANNELS];

  // Handshakes: the pipeline never stalls
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // Target channel register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= sdm_pkg::count_t'(2);
    end else if (cfg_valid_i && cfg_ready_o) begin
      target_q <= cfg_data_i;
    end
  end

  assign smp_in[0] = in_0_i;
  assign smp_in[1] = in_1_i;
  assign smp_in[2] = in_2_i;
  assign smp_in[3] = in_3_i;
  assign smp_in[4] = in_4_i;
  assign smp_in[5] = in_5_i;
  assign smp_in[6] = in_6_i;
  assign smp_in[7] = in_7_i;

  sdm_input u_input (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .num_in_i (num_in_channels_i),
    .target_i (target_q),
    .smp_i    (smp_in),
    .ctrl_o   (in_ctrl),
    .smp_o    (in_smp),
    .sum_o    (in_sum),
    .gain_o   (in_gain)
  );

  sdm_mix u_mix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (in_ctrl),
    .smp_i  (in_smp),
    .sum_i  (in_sum),
    .gain_i (in_gain),
    .ctrl_o (mix_ctrl),
    .acc_o  (mix_acc)
  );

  sdm_finish u_finish (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mix_ctrl),
    .acc_i    (mix_acc),
    .strobe_o (strobe_o),
    .count_o  (out_count_o),
    .out_o    (res)
  );

  assign out_0_o = res[0];
  assign out_1_o = res[1];
  assign out_2_o = res[2];
  assign out_3_o = res[3];
  assign out_4_o = res[4];
  assign out_5_o = res[5];
  assign out_6_o = res[6];
  assign out_7_o = res[7];

endmodule
`default_nettype wire
